@@ src/bpcd_pkg.sv @@
// Shared types, constants and compare helpers for the bottleneck path column unit.
// No dependencies; used by bpcd_front, bpcd_cell and bottleneck_path_column_dp_unit.
package bpcd_pkg;

    localparam int ROWS_MAX   = 64;
    localparam int VALUE_W    = 32;
    localparam int ROW_W      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int ROWS_W     = $clog2(ROWS_MAX + 1);
    localparam int CFG_ROWS_W = 7;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Register index taken from paddr above the byte offset.
    localparam logic [APB_AW-3:0] REG_ROWS_IDX = '0;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(64);

    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_value INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // One element in flight along the chain.
    typedef struct packed {
        logic             valid;
        t_value           value;
        logic [ROW_W-1:0] row;
        logic             first;   // element belongs to the first column
        logic             below;   // a row below exists in this matrix
        logic             last;
        t_value           cmax;    // running column maximum once worked
    } t_item;

    // What a cell shows to its neighbours.
    typedef struct packed {
        t_value val;     // stored entry
        t_value old;     // entry before its latest write
        t_value cmax;    // column maximum after its latest write
        logic   wr;      // cell writes this cycle unless the chain holds
        t_value nf_val;  // value being written, computed without forwarding
    } t_nbr;

    localparam t_nbr NBR_IDLE = '0;

    function automatic t_value smax(input t_value a, input t_value b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_value smin(input t_value a, input t_value b);
        return (a > b) ? b : a;
    endfunction

endpackage

@@ src/bottleneck_path_column_dp_unit.sv @@
// Top level: APB row-count register, row sequencer, chain of cells, output skid.
// Depends on bpcd_pkg, bpcd_front and bpcd_cell.
//
//  channel   dir  handshake                      payload
//  -------   ---  -----------------------------  -----------------------------------
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: value, tuser: start_req,
//                                                 tlast: last
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: max_sharpness
//  apb       in   psel, penable, pwrite, pready   paddr, pwdata, prdata (rows_in_use at 0)
//
// One element per cycle while the skid is empty. Each element passes all 64 cells in turn
// and is worked in its row's cell; a result is registered at the output after the last cell.
// Reset is synchronous and clears only control state; the stored column needs no clearing.
// A result waiting at the output does not stop the chain; a one-entry skid takes the next
// one, and only while the skid is full does the chain hold and the input refuse transfers.
module bottleneck_path_column_dp_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // stream in
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,  // [31:0] value
    input  logic [0:0]                       i_s_axis_tuser,  // [0] start_req
    input  logic                             i_s_axis_tlast,
    // stream out
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [31:0]                      o_m_axis_tdata,  // [31:0] max_sharpness
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpcd_pkg::APB_AW-1:0]      paddr,
    input  logic [bpcd_pkg::APB_DW-1:0]      pwdata,
    output logic [bpcd_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    logic [bpcd_pkg::CFG_ROWS_W-1:0] r_rows;
    logic                            cfg_wr;

    logic                            en;
    logic                            in_accept;
    logic                            out_fire;
    logic                            res;

    logic                            r_out_valid;
    bpcd_pkg::t_value                r_out_data;
    logic                            r_sk_valid;
    bpcd_pkg::t_value                r_sk_data;

    bpcd_pkg::t_item                 w_item [bpcd_pkg::ROWS_MAX+1];
    bpcd_pkg::t_nbr                  w_nbr  [bpcd_pkg::ROWS_MAX];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[bpcd_pkg::APB_AW-1:2] == bpcd_pkg::REG_ROWS_IDX);

    always_comb begin
        if (paddr[bpcd_pkg::APB_AW-1:2] == bpcd_pkg::REG_ROWS_IDX) begin
            prdata = bpcd_pkg::APB_DW'(r_rows);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= bpcd_pkg::ROWS_RESET;
        end else if (cfg_wr) begin
            r_rows <= pwdata[bpcd_pkg::CFG_ROWS_W-1:0];
        end
    end

    // the chain advances unless the skid is holding a result
    assign en              = !r_sk_valid;
    assign o_s_axis_tready = en;
    assign in_accept       = i_s_axis_tvalid && en;

    bpcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rows_cfg (r_rows),
        .i_accept   (in_accept),
        .i_value    (i_s_axis_tdata),
        .i_start    (i_s_axis_tuser[0]),
        .i_last     (i_s_axis_tlast),
        .o_item     (w_item[0])
    );

    for (genvar k = 0; k < bpcd_pkg::ROWS_MAX; k++) begin : g_cell
        bpcd_pkg::t_nbr above;
        bpcd_pkg::t_nbr below;

        if (k == 0) begin : g_top
            assign above = bpcd_pkg::NBR_IDLE;
        end else begin : g_mid
            assign above = w_nbr[k-1];
        end

        if (k == bpcd_pkg::ROWS_MAX - 1) begin : g_bot
            assign below = bpcd_pkg::NBR_IDLE;
        end else begin : g_inner
            assign below = w_nbr[k+1];
        end

        bpcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_index (bpcd_pkg::ROW_W'(k)),
            .i_item  (w_item[k]),
            .i_above (above),
            .i_below (below),
            .o_item  (w_item[k+1]),
            .o_nbr   (w_nbr[k])
        );
    end

    // output register and skid
    assign res      = w_item[bpcd_pkg::ROWS_MAX].valid && w_item[bpcd_pkg::ROWS_MAX].last;
    assign out_fire = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (out_fire) begin
                r_sk_valid <= 1'b0;
            end
        end else if (res) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_sk_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (out_fire) begin
                r_out_data <= r_sk_data;
            end
        end else if (res) begin
            if (!r_out_valid || out_fire) begin
                r_out_data <= w_item[bpcd_pkg::ROWS_MAX].cmax;
            end else begin
                r_sk_data <= w_item[bpcd_pkg::ROWS_MAX].cmax;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && !i_m_axis_tready && res))
        else $error("skid filled without a stalled output");
`endif

endmodule

@@ src/bpcd_front.sv @@
// Row sequencer: tracks row index and first-column state, tags each element.
// Depends on bpcd_pkg.
module bpcd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bpcd_pkg::CFG_ROWS_W-1:0]    i_rows_cfg,
    input  logic                               i_accept,
    input  bpcd_pkg::t_value                   i_value,
    input  logic                               i_start,
    input  logic                               i_last,
    output bpcd_pkg::t_item                    o_item
);

    logic [bpcd_pkg::ROW_W-1:0]  r_row_idx;
    logic                        r_first;
    logic [bpcd_pkg::ROW_W-1:0]  n_row_idx;
    logic                        n_first;

    logic [bpcd_pkg::ROWS_W-1:0] rows_eff;
    logic [bpcd_pkg::ROW_W-1:0]  idx_s;
    logic                        first_s;
    logic [bpcd_pkg::ROW_W-1:0]  row;
    logic                        first;
    logic [bpcd_pkg::ROWS_W-1:0] row_next;
    logic                        has_below;

    always_comb begin
        if (i_rows_cfg == '0) begin
            rows_eff = bpcd_pkg::ROWS_W'(1);
        end else if (int'(i_rows_cfg) > bpcd_pkg::ROWS_MAX) begin
            rows_eff = bpcd_pkg::ROWS_W'(bpcd_pkg::ROWS_MAX);
        end else begin
            rows_eff = bpcd_pkg::ROWS_W'(i_rows_cfg);
        end

        idx_s   = i_start ? '0 : r_row_idx;
        first_s = i_start ? 1'b1 : r_first;

        // index past the row count closes the column
        if (bpcd_pkg::ROWS_W'(idx_s) >= rows_eff) begin
            row   = '0;
            first = 1'b0;
        end else begin
            row   = idx_s;
            first = first_s;
        end

        row_next  = bpcd_pkg::ROWS_W'(row) + bpcd_pkg::ROWS_W'(1);
        has_below = (row_next < rows_eff);

        if (i_last) begin
            n_row_idx = '0;
            n_first   = 1'b1;
        end else if (!has_below) begin
            n_row_idx = '0;
            n_first   = 1'b0;
        end else begin
            n_row_idx = row_next[bpcd_pkg::ROW_W-1:0];
            n_first   = first;
        end

        o_item.valid = i_accept;
        o_item.value = i_value;
        o_item.row   = row;
        o_item.first = first;
        o_item.below = has_below;
        o_item.last  = i_last;
        o_item.cmax  = bpcd_pkg::INT_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx <= '0;
            r_first   <= 1'b1;
        end else if (i_accept) begin
            r_row_idx <= n_row_idx;
            r_first   <= n_first;
        end
    end

`ifndef NO_ASSERTIONS
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_row_idx == '0 && r_first))
        else $error("row sequencer did not restart after the final element");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last && has_below) |=>
            (bpcd_pkg::ROWS_W'(r_row_idx) == $past(row_next)))
        else $error("row index did not advance by one");
`endif

endmodule

@@ src/bpcd_cell.sv @@
// One cell of the chain: stage register for the passing element plus the stored
// previous-column entry of its own row. Depends on bpcd_pkg.
module bpcd_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [bpcd_pkg::ROW_W-1:0]  i_index,
    input  bpcd_pkg::t_item             i_item,
    input  bpcd_pkg::t_nbr              i_above,
    input  bpcd_pkg::t_nbr              i_below,
    output bpcd_pkg::t_item             o_item,
    output bpcd_pkg::t_nbr              o_nbr
);

    bpcd_pkg::t_item  r_item;
    bpcd_pkg::t_value r_val;
    bpcd_pkg::t_value r_old;
    bpcd_pkg::t_value r_cmax;

    logic             act;
    bpcd_pkg::t_value best_base;
    bpcd_pkg::t_value below_eff;
    bpcd_pkg::t_value best;
    bpcd_pkg::t_value best_nf;
    bpcd_pkg::t_value cell_v;
    bpcd_pkg::t_value cell_nf;
    bpcd_pkg::t_value cmax_new;

    always_comb begin
        act = r_item.valid && (r_item.row == i_index);

        best_base = r_val;
        if (r_item.row != '0) begin
            best_base = bpcd_pkg::smax(best_base, i_above.old);
        end

        // take the neighbour's new entry when it is written in this same cycle
        below_eff = i_below.wr ? i_below.nf_val : i_below.val;
        best      = r_item.below ? bpcd_pkg::smax(best_base, below_eff) : best_base;
        best_nf   = r_item.below ? bpcd_pkg::smax(best_base, i_below.val) : best_base;

        cell_v  = r_item.first ? r_item.value : bpcd_pkg::smin(best, r_item.value);
        cell_nf = r_item.first ? r_item.value : bpcd_pkg::smin(best_nf, r_item.value);

        cmax_new = (r_item.row == '0) ? cell_v : bpcd_pkg::smax(i_above.cmax, cell_v);

        o_item = r_item;
        if (act) begin
            o_item.cmax = cmax_new;
        end

        o_nbr.val    = r_val;
        o_nbr.old    = r_old;
        o_nbr.cmax   = r_cmax;
        o_nbr.wr     = act;
        o_nbr.nf_val = cell_nf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && act) begin
            r_val  <= cell_v;
            r_old  <= r_val;
            r_cmax <= cmax_new;
        end
    end

`ifndef NO_ASSERTIONS
    a_first_column_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && act && r_item.first) |=> (r_val == $past(r_item.value)))
        else $error("first-column element not stored as it arrived");
`endif

endmodule

@@ tb/bottleneck_path_column_dp_unit_test.sv @@
// Self-checking testbench for bottleneck_path_column_dp_unit: column-major matrices in,
// bottleneck path maxima out, each checked against an in-bench predictor of the column update.
// Depends on bpcd_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 1ps

module bottleneck_path_column_dp_unit_test;
    import bpcd_pkg::*;

    localparam t_value VALUE_MAX = ~INT_MIN;
    localparam logic [APB_AW-1:0] ROWS_ADDR = {REG_ROWS_IDX, 2'b00};
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 100;  // margin for an element to clear the chain and the output register

    typedef enum {MAT_CLEAN, MAT_CUT, MAT_RESTART} t_matrix_shape;

    // Predicts max_sharpness for each matrix and holds the maxima still owed by the unit.
    class sharpness_board;
        t_value column[ROWS_MAX];
        t_value above_old;
        int row_next;
        bit in_first_col;
        t_value col_max;
        logic [CFG_ROWS_W-1:0] rows_cfg;
        t_value pending_maxima[$];
        int mismatches;

        function new();
            foreach (column[i]) column[i] = '0;
            above_old = '0;
            rows_cfg = ROWS_RESET;
            mismatches = 0;
            restart_matrix();
        endfunction

        function void restart_matrix();
            row_next = 0;
            in_first_col = 1'b1;
            col_max = INT_MIN;
        endfunction

        function void note_element(t_value v, bit start, bit is_last);
            int rows;
            int r;
            t_value here;
            t_value best;
            t_value upd;
            rows = int'(rows_cfg);
            if (rows < 1) rows = 1;
            if (rows > ROWS_MAX) rows = ROWS_MAX;
            if (start) restart_matrix();
            // row count lowered mid column: close the column here
            if (row_next >= rows) begin
                row_next = 0;
                in_first_col = 1'b0;
            end
            r = row_next;
            here = column[r];
            if (in_first_col) begin
                upd = v;
            end else begin
                best = here;
                if (r > 0 && above_old > best) best = above_old;
                if (r + 1 < rows && column[r + 1] > best) best = column[r + 1];
                upd = (best > v) ? v : best;
            end
            above_old = here;
            column[r] = upd;
            col_max = (r == 0 || upd > col_max) ? upd : col_max;
            if (r + 1 >= rows) begin
                row_next = 0;
                in_first_col = 1'b0;
            end else begin
                row_next = r + 1;
            end
            if (is_last) begin
                pending_maxima.push_back(col_max);
                restart_matrix();
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_sharpness(t_value got);
            t_value want;
            if (pending_maxima.size() == 0) begin
                report_mismatch($sformatf("max_sharpness %0d with none outstanding", got));
            end else begin
                want = pending_maxima.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("max_sharpness %0d, want %0d", got, want));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // [31:0] value
    logic [0:0] i_s_axis_tuser = '0;   // [0] start_req
    logic i_s_axis_tlast = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;       // [31:0] max_sharpness
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    sharpness_board board;
    int send_idle_pct = 28;
    int recv_idle_pct = 87;
    int elems_sent = 0;
    int cycle_count = 0;

    bottleneck_path_column_dp_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample both transfers at the edge that completes them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_sharpness(t_value'(o_m_axis_tdata));
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_element(t_value'(i_s_axis_tdata), i_s_axis_tuser[0],
                                   i_s_axis_tlast);
        end
    end

    function automatic t_value pick_value();
        case ($urandom_range(9))
            0: return INT_MIN;
            1: return VALUE_MAX;
            2, 3: return t_value'($urandom_range(8)) - 4;
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic send_element(t_value v, bit start, bit is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= v;
        i_s_axis_tuser <= start;
        i_s_axis_tlast <= is_last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        elems_sent++;
    endtask

    // Hold off until every owed maximum is out and the chain has emptied.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_maxima.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rows(logic [CFG_ROWS_W-1:0] rows);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ROWS_ADDR;
        pwdata <= APB_DW'(rows);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.rows_cfg = rows;
    endtask

    task automatic send_matrix(int rows_eff, int cols, t_matrix_shape shape);
        int total;
        int cut;
        int restart_at;
        bit start;
        total = rows_eff * cols;
        cut = (shape == MAT_CUT) ? $urandom_range(total - 1) : total - 1;
        restart_at = (shape == MAT_RESTART && total > 1) ? $urandom_range(total - 1, 1) : -1;
        for (int i = 0; i <= cut; i++) begin
            start = (i == 0) ? bit'($urandom_range(1)) : (i == restart_at);
            send_element(pick_value(), start, i == cut);
        end
    endtask

    initial begin
        int rows_cfg;
        int rows_eff;
        int cols;
        int pick;
        int phase;
        t_matrix_shape shape;

        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of the value field through a full 3x3 matrix.
        write_rows(CFG_ROWS_W'(3));
        send_element(INT_MIN, 1'b1, 1'b0);
        send_element(VALUE_MAX, 1'b0, 1'b0);
        send_element('0, 1'b0, 1'b0);
        send_element(-1, 1'b0, 1'b0);
        send_element(VALUE_MAX, 1'b0, 1'b0);
        send_element(INT_MIN, 1'b0, 1'b0);
        send_element(VALUE_MAX, 1'b0, 1'b0);
        send_element(1, 1'b0, 1'b0);
        send_element(-1, 1'b0, 1'b1);
        // Start in mid column, then a last in mid column.
        send_element(10, 1'b1, 1'b0);
        send_element(20, 1'b0, 1'b0);
        send_element(30, 1'b1, 1'b0);
        send_element(40, 1'b0, 1'b0);
        send_element(50, 1'b0, 1'b0);
        send_element(60, 1'b0, 1'b0);
        send_element(70, 1'b0, 1'b1);
        // Lower the row count while a column is half done.
        send_element(1, 1'b1, 1'b0);
        send_element(2, 1'b0, 1'b0);
        send_element(3, 1'b0, 1'b0);
        send_element(4, 1'b0, 1'b0);
        send_element(5, 1'b0, 1'b0);
        wait_drained();
        write_rows(CFG_ROWS_W'(1));
        send_element(6, 1'b0, 1'b0);
        send_element(7, 1'b0, 1'b1);
        wait_drained();
        // A row count of zero behaves as one.
        write_rows(CFG_ROWS_W'(0));
        send_element(INT_MIN, 1'b1, 1'b0);
        send_element(VALUE_MAX, 1'b0, 1'b1);
        wait_drained();

        phase = 0;
        while (elems_sent < 800) begin
            if (elems_sent < 270) begin
                send_idle_pct = 28;
                recv_idle_pct = 87;
            end else if (elems_sent < 540) begin
                send_idle_pct = 87;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (phase == 0) rows_cfg = 127;
            else if (phase == 1) rows_cfg = ROWS_MAX;
            else if (pick < 8) rows_cfg = 0;
            else if (pick < 70) rows_cfg = $urandom_range(8, 1);
            else if (pick < 85) rows_cfg = $urandom_range(63, 9);
            else if (pick < 93) rows_cfg = ROWS_MAX;
            else rows_cfg = $urandom_range(127, 65);
            rows_eff = (rows_cfg < 1) ? 1 : (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;
            write_rows(rows_cfg[CFG_ROWS_W-1:0]);
            repeat ((rows_eff > 8) ? 1 : $urandom_range(4, 1)) begin
                cols = (rows_eff > 8) ? $urandom_range(2, 1) : $urandom_range(5, 1);
                pick = $urandom_range(99);
                shape = (pick < 70) ? MAT_CLEAN : (pick < 85) ? MAT_CUT : MAT_RESTART;
                send_matrix(rows_eff, cols, shape);
            end
            // Always close the matrix before the row count may rise.
            send_element(pick_value(), 1'b1, 1'b1);
            wait_drained();
            phase++;
        end

        if (board.pending_maxima.size() != 0)
            board.report_mismatch($sformatf("%0d maxima never delivered",
                                            board.pending_maxima.size()));
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
